/* hw/rtl/m61_pkg.sv */
`timescale 1ns / 1ps
package m61_pkg;
	localparam int ElemW = 61;
	localparam int ExpW = 64;
	localparam logic [ElemW-1:0] FieldP = {ElemW{1'b1}};
	localparam logic [ExpW-1:0] InvExp = 64'd2305843009213693949;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_POW = 2'd1,
		OP_INV = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_MULB,
		ST_DONE
	} state_t;

	function automatic logic [ElemW-1:0] fold_full(input logic [63:0] x);
		logic [62:0] s;
		s = {60'd0, x[63:61]} + {2'd0, x[60:0]};
		if (s >= {2'd0, FieldP}) s = s - {2'd0, FieldP};
		return s[ElemW-1:0];
	endfunction
endpackage

/* hw/rtl/m61_mul.sv */
`timescale 1ns / 1ps
// Field multiplier: four 32x32 partial products, one per cycle, then a fold.
module m61_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [m61_pkg::ElemW-1:0] x,
	input  logic [m61_pkg::ElemW-1:0] y,
	output logic done,
	output logic [m61_pkg::ElemW-1:0] prod
);
	logic [2:0] cnt_q;
	logic [m61_pkg::ElemW-1:0] x_q, y_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [63:0] hh_q, mid_q, ll_q;
	logic [63:0] sum;

	always_comb begin
		case (cnt_q)
			3'd1: begin pa = {3'd0, x_q[60:32]}; pb = {3'd0, y_q[60:32]}; end
			3'd2: begin pa = {3'd0, x_q[60:32]}; pb = y_q[31:0]; end
			3'd3: begin pa = x_q[31:0]; pb = {3'd0, y_q[60:32]}; end
			default: begin pa = x_q[31:0]; pb = y_q[31:0]; end
		endcase
		pp = pa * pb;
		sum = (hh_q << 3) + (mid_q >> 29) + {3'd0, mid_q[28:0], 32'd0}
			+ (ll_q >> 61) + {3'd0, ll_q[60:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				cnt_q <= 3'd1;
			end else if (cnt_q == 3'd5) begin
				cnt_q <= 3'd0;
				done <= 1'b1;
			end else if (cnt_q != 3'd0) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= x;
			y_q <= y;
			mid_q <= '0;
		end
		case (cnt_q)
			3'd1: hh_q <= pp;
			3'd2: mid_q <= pp;
			3'd3: mid_q <= mid_q + pp;
			3'd4: ll_q <= pp;
			3'd5: prod <= m61_pkg::fold_full(sum);
			default: ;
		endcase
	end
endmodule

/* hw/rtl/mersenne61_modular_alu_top.sv */
`timescale 1ns / 1ps
// One transaction at a time; busy is high while it runs. Every field product goes through one
// shared multiplier, which is started, forms four 32x32 partial products, folds, and has its
// result taken. Power and inverse run 64 square-and-multiply rounds, one squaring each plus
// one multiply per set exponent bit. An inverse of zero and the unused operation code skip
// the multiplier. The result strobe lasts one cycle and cannot be held off by the receiver.
module mersenne61_modular_alu_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] operation,
	input  logic [60:0] operand_a,
	input  logic [63:0] operand_b,
	output logic result_valid,
	output logic [60:0] result_value,
	output logic no_inverse
);
	m61_pkg::state_t state_q, state_d;
	m61_pkg::op_t op_q;
	logic [60:0] base_q, acc_q, mx, my;
	logic [63:0] exp_q;
	logic [5:0] bit_q;
	logic mgo, mdone, go_q;
	logic [60:0] mprod;
	logic take;
	logic [60:0] a_red;

	assign take = start && !busy;
	assign a_red = m61_pkg::fold_full({3'd0, operand_a});

	m61_mul u_mul (.clk(clk), .arst_n(arst_n), .go(mgo), .x(mx), .y(my),
		.done(mdone), .prod(mprod));

	always_comb begin
		state_d = state_q;
		case (state_q)
			m61_pkg::ST_IDLE: if (take) begin
				if (operation == m61_pkg::OP_POW ||
					(operation == m61_pkg::OP_INV && a_red != '0))
					state_d = m61_pkg::ST_SQR;
				else if (operation == m61_pkg::OP_MUL) state_d = m61_pkg::ST_MULB;
				else state_d = m61_pkg::ST_DONE;
			end
			m61_pkg::ST_SQR: if (mdone) begin
				if (exp_q[bit_q]) state_d = m61_pkg::ST_MULB;
				else if (bit_q == 6'd0) state_d = m61_pkg::ST_DONE;
			end
			m61_pkg::ST_MULB: if (mdone) begin
				if (op_q == m61_pkg::OP_MUL || bit_q == 6'd0) state_d = m61_pkg::ST_DONE;
				else state_d = m61_pkg::ST_SQR;
			end
			m61_pkg::ST_DONE: state_d = m61_pkg::ST_IDLE;
			default: state_d = m61_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != m61_pkg::ST_IDLE;
		mgo = go_q;
		mx = acc_q;
		my = (state_q == m61_pkg::ST_SQR) ? acc_q : base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m61_pkg::ST_IDLE;
			go_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q <= (state_q == m61_pkg::ST_IDLE && take &&
				state_d != m61_pkg::ST_DONE) ||
				(mdone && state_d != m61_pkg::ST_DONE);
			result_valid <= state_q == m61_pkg::ST_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q <= m61_pkg::op_t'(operation);
			base_q <= a_red;
			bit_q <= 6'd63;
			no_inverse <= operation == m61_pkg::OP_INV && a_red == '0;
			result_value <= '0;
			if (operation == m61_pkg::OP_MUL) begin
				acc_q <= m61_pkg::fold_full(operand_b);
				exp_q <= operand_b;
			end else begin
				acc_q <= 61'd1;
				exp_q <= (operation == m61_pkg::OP_INV) ? m61_pkg::InvExp : operand_b;
			end
		end else if (mdone) begin
			acc_q <= mprod;
			if (state_q == m61_pkg::ST_SQR ? !exp_q[bit_q] : 1'b1)
				bit_q <= bit_q - 6'd1;
		end
		if (state_q == m61_pkg::ST_DONE &&
			(op_q == m61_pkg::OP_MUL || op_q == m61_pkg::OP_POW ||
			(op_q == m61_pkg::OP_INV && !no_inverse)))
			result_value <= acc_q;
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while busy");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double strobe");
	a_red_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_value != m61_pkg::FieldP) else $error("not reduced");
endmodule
